>>> rtl/bmms_pkg.sv
// ---------------------------------------------------------------------------
// Binned min/max/mean statistics: shared package
// Sizes, command and status codes, and the payload and bin entry types.
// ---------------------------------------------------------------------------
package bmms_pkg;

  localparam int NUM_BINS   = 12;
  localparam int COUNT_BITS = 24;

  localparam int TEMP_BITS    = 8;
  localparam int OUT_CNT_BITS = 24;
  localparam int MEAN_BITS    = 16;
  localparam int FRAC_BITS    = 8;

  localparam int ADDR_BITS    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SCAN_BITS    = $clog2(NUM_BINS + 1);
  // A bin sum needs the count width plus the sample width.
  localparam int SUM_BITS     = COUNT_BITS + TEMP_BITS;
  localparam int TCNT_BITS    = COUNT_BITS + ADDR_BITS;
  localparam int TSUM_BITS    = SUM_BITS + ADDR_BITS;
  localparam int DIV_W        = TSUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(MEAN_BITS);

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [OUT_CNT_BITS-1:0] OUT_COUNT_MAX = {OUT_CNT_BITS{1'b1}};

  localparam logic signed [TEMP_BITS-1:0] FLOOR_RESET   = -8'sd99;
  localparam logic signed [TEMP_BITS-1:0] CEILING_RESET = 8'sd99;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING = 1'd1;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_TOTAL = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_MONTH = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_SATURATED = 2'd3;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [3:0]                  month;
    logic signed [TEMP_BITS-1:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [OUT_CNT_BITS-1:0]     sample_count;
    logic signed [TEMP_BITS-1:0] min_temp;
    logic signed [TEMP_BITS-1:0] max_temp;
    logic signed [MEAN_BITS-1:0] mean_temp;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]       count;
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [TEMP_BITS-1:0] mn;
    logic signed [TEMP_BITS-1:0] mx;
  } bin_entry_t;

  localparam int ENTRY_BITS = $bits(bin_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

>>> rtl/bmms_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module bmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/binned_min_max_mean_stats_unit.sv
// ---------------------------------------------------------------------------
// Binned min/max/mean statistics unit
// Keeps count, sum, minimum and maximum for each month bin in one RAM and
// answers add, month query and total query commands with one word each.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       into unit  in_valid / in_stall  in_data  (cmd, month, temperature)
//  out      from unit  out_valid / out_stall out_data (status, count, min, max, mean)
//  cfg      into unit  cfg_we               cfg_index, cfg_data
//
// An add or month query reads its one bin, a total query sweeps the RAM bin by
// bin, and each then passes through the restoring divider that forms the mean.
// One word is worked on at a time; the output register lets the next word be
// accepted while a result still waits under out_stall.
// Reset clears the bin valid flags, so every bin reads as empty at once.
//
module binned_min_max_mean_stats_unit
  import bmms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_word_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_word_t               out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TEMP_BITS-1:0]    cfg_data
);

  state_t state, state_next;

  logic signed [TEMP_BITS-1:0] temp_floor, temp_ceiling;

  logic [1:0]                  cmd_q;
  logic signed [TEMP_BITS-1:0] temp_q;
  logic [ADDR_BITS-1:0]        addr_q;
  logic [SCAN_BITS-1:0]        scan_idx;

  logic [NUM_BINS-1:0]  vld;
  logic                 rd_vld;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic                 ram_we;
  logic [ENTRY_BITS-1:0] ram_rdata;
  bin_entry_t           entry, upd_entry;

  logic [1:0]                  acc_status;
  logic [TCNT_BITS-1:0]        acc_count;
  logic signed [TSUM_BITS-1:0] acc_sum;
  logic signed [TEMP_BITS-1:0] acc_min, acc_max;

  logic                    neg;
  logic [DIV_W-1:0]        rem, den_sh;
  logic [MEAN_BITS-1:0]    quot;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    div_ge;
  logic [TSUM_BITS-1:0]    sum_mag;

  logic                 in_accept, month_ok, is_total, slot_free;
  logic [ADDR_BITS-1:0] in_addr;
  logic [1:0]           add_status;
  logic signed [MEAN_BITS-1:0] mean_val;

  assign in_accept = in_valid && !in_stall;
  assign month_ok  = (in_data.month != 4'd0) && (32'(in_data.month) <= NUM_BINS);
  assign is_total  = (in_data.cmd != CMD_ADD) && (in_data.cmd != CMD_QUERY);
  assign in_addr   = ADDR_BITS'({{ADDR_BITS{1'b0}}, in_data.month} - 1'b1);
  assign slot_free = !out_valid || !out_stall;

  // Bins never written read as empty.
  assign entry = rd_vld ? bin_entry_t'(ram_rdata) : '0;

  always_comb begin
    priority if (temp_q < temp_floor || temp_q > temp_ceiling) begin
      add_status = STAT_RANGE;
    end else if (entry.count == COUNT_MAX) begin
      add_status = STAT_SATURATED;
    end else begin
      add_status = STAT_OK;
    end
  end

  always_comb begin
    upd_entry       = entry;
    upd_entry.count = entry.count + 1'b1;
    upd_entry.sum   = entry.sum + SUM_BITS'(temp_q);
    if (entry.count == '0 || temp_q < entry.mn) begin
      upd_entry.mn = temp_q;
    end
    if (entry.count == '0 || temp_q > entry.mx) begin
      upd_entry.mx = temp_q;
    end
  end

  bmms_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (upd_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          priority if (is_total) begin
            state_next = S_SCAN;
          end else if (!month_ok) begin
            state_next = S_PREP;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_PREP;
      S_SCAN: begin
        if (32'(scan_idx) == NUM_BINS) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = is_total ? '0 : in_addr;
      end
      S_READ: ram_we = (cmd_q == CMD_ADD) && (add_status == STAT_OK);
      S_SCAN: begin
        if (32'(scan_idx) < NUM_BINS) begin
          ram_raddr = ADDR_BITS'(scan_idx);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vld          <= '0;
      temp_floor   <= FLOOR_RESET;
      temp_ceiling <= CEILING_RESET;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vld[addr_q] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FLOOR:   temp_floor   <= cfg_data;
          REG_CEILING: temp_ceiling <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[ram_raddr];
  end

  assign sum_mag = acc_sum[TSUM_BITS-1] ? TSUM_BITS'(-acc_sum) : TSUM_BITS'(acc_sum);
  assign div_ge  = (rem >= den_sh);

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd_q      <= in_data.cmd;
          temp_q     <= in_data.temperature;
          addr_q     <= in_addr;
          scan_idx   <= SCAN_BITS'(1);
          acc_status <= (!is_total && !month_ok) ? STAT_BAD_MONTH : STAT_OK;
          acc_count  <= '0;
          acc_sum    <= '0;
          acc_min    <= '0;
          acc_max    <= '0;
        end
      end
      S_READ: begin
        if (cmd_q == CMD_ADD && add_status == STAT_OK) begin
          acc_count <= TCNT_BITS'(upd_entry.count);
          acc_sum   <= TSUM_BITS'(upd_entry.sum);
          acc_min   <= upd_entry.mn;
          acc_max   <= upd_entry.mx;
        end else begin
          acc_count <= TCNT_BITS'(entry.count);
          acc_sum   <= TSUM_BITS'(entry.sum);
          acc_min   <= entry.mn;
          acc_max   <= entry.mx;
        end
        if (cmd_q == CMD_ADD) begin
          acc_status <= add_status;
        end
      end
      S_SCAN: begin
        if (32'(scan_idx) < NUM_BINS) begin
          scan_idx <= scan_idx + 1'b1;
        end
        // Empty bins take no part in the total.
        if (entry.count != '0) begin
          acc_count <= acc_count + TCNT_BITS'(entry.count);
          acc_sum   <= acc_sum + TSUM_BITS'(entry.sum);
          if (acc_count == '0 || entry.mn < acc_min) begin
            acc_min <= entry.mn;
          end
          if (acc_count == '0 || entry.mx > acc_max) begin
            acc_max <= entry.mx;
          end
        end
      end
      S_PREP: begin
        neg     <= acc_sum[TSUM_BITS-1];
        rem     <= DIV_W'(sum_mag) << FRAC_BITS;
        den_sh  <= DIV_W'(acc_count) << (MEAN_BITS - 1);
        quot    <= '0;
        div_cnt <= DIV_CNT_BITS'(MEAN_BITS - 1);
      end
      S_DIV: begin
        if (div_ge) begin
          rem <= rem - den_sh;
        end
        quot    <= {quot[MEAN_BITS-2:0], div_ge};
        den_sh  <= den_sh >> 1;
        div_cnt <= div_cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign mean_val = (acc_count == '0) ? '0 :
                    (neg ? $signed(-quot) : $signed(quot));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      out_data.status       <= acc_status;
      out_data.sample_count <= (acc_count > TCNT_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                               : OUT_CNT_BITS'(acc_count);
      out_data.min_temp     <= acc_min;
      out_data.max_temp     <= acc_max;
      out_data.mean_temp    <= mean_val;
    end
  end

  a_write_sets_valid : assert property (@(posedge clk) disable iff (rst)
    ram_we |=> vld[$past(addr_q)])
    else $error("bin written but its valid flag is not set");

  a_div_ends : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == '0) |=> state == S_DONE)
    else $error("divider did not finish after its last step");

  a_result_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word appeared outside the done state");

  a_bad_month_empty : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STAT_BAD_MONTH) |->
      (out_data.sample_count == '0 && out_data.mean_temp == '0))
    else $error("bad month result carries bin data");

endmodule

>>> bench/bmms_stats_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Statistics unit checker
// Watches the command, result and register ports, keeps its own copy of the
// month bins and the temperature limits, and compares each result word field
// by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module bmms_stats_checker
  import bmms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_word_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_word_t               out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TEMP_BITS-1:0]    cfg_data,
  output int                      failures,
  output int                      pending
);

  localparam longint unsigned BIN_FULL = (64'd1 << COUNT_BITS) - 64'd1;

  longint unsigned bin_tally [NUM_BINS];
  longint          bin_total [NUM_BINS];
  int              bin_low   [NUM_BINS];
  int              bin_high  [NUM_BINS];
  int              floor_lim;
  int              ceiling_lim;
  out_word_t       awaited_words [$];
  int              mismatch_count = 0;
  int              pending_words  = 0;

  assign failures = mismatch_count;
  assign pending  = pending_words;

  function automatic out_word_t summarise(logic [1:0] st, longint unsigned cnt,
                                          longint sum, int mn, int mx);
    out_word_t w;
    longint    avg;
    avg = 0;
    if (cnt != 0) begin
      avg = (sum * 256) / longint'(cnt);
    end else begin
      mn = 0;
      mx = 0;
    end
    w.status       = st;
    w.sample_count = (cnt > OUT_COUNT_MAX) ? OUT_COUNT_MAX : cnt[OUT_CNT_BITS-1:0];
    w.min_temp     = mn[TEMP_BITS-1:0];
    w.max_temp     = mx[TEMP_BITS-1:0];
    w.mean_temp    = avg[MEAN_BITS-1:0];
    return w;
  endfunction

  function automatic out_word_t report_bin(logic [1:0] st, int b);
    return summarise(st, bin_tally[b], bin_total[b], bin_low[b], bin_high[b]);
  endfunction

  // Updates the bins for one command and returns the word it should produce.
  function automatic out_word_t apply_command(in_word_t w);
    int              t;
    int              b;
    bit              month_ok;
    longint unsigned cnt;
    longint          sum;
    int              mn;
    int              mx;
    bit              any;
    t        = w.temperature;
    month_ok = (w.month >= 1) && (w.month <= NUM_BINS);
    b        = month_ok ? int'(w.month) - 1 : 0;
    if (w.cmd == CMD_ADD || w.cmd == CMD_QUERY) begin
      if (!month_ok) return summarise(STAT_BAD_MONTH, 0, 0, 0, 0);
      if (w.cmd == CMD_QUERY) return report_bin(STAT_OK, b);
      if (t < floor_lim || t > ceiling_lim) return report_bin(STAT_RANGE, b);
      if (bin_tally[b] >= BIN_FULL) return report_bin(STAT_SATURATED, b);
      if (bin_tally[b] == 0) begin
        bin_low[b]  = t;
        bin_high[b] = t;
      end else begin
        if (t < bin_low[b]) bin_low[b] = t;
        if (t > bin_high[b]) bin_high[b] = t;
      end
      bin_tally[b] += 1;
      bin_total[b] += t;
      return report_bin(STAT_OK, b);
    end
    // Total query, and the spare command code: empty bins take no part.
    cnt = 0;
    sum = 0;
    mn  = 0;
    mx  = 0;
    any = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      if (bin_tally[i] != 0) begin
        cnt += bin_tally[i];
        sum += bin_total[i];
        if (!any || bin_low[i] < mn) mn = bin_low[i];
        if (!any || bin_high[i] > mx) mx = bin_high[i];
        any = 1'b1;
      end
    end
    return summarise(STAT_OK, cnt, sum, mn, mx);
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bin_tally[i] = 0;
        bin_total[i] = 0;
        bin_low[i]   = 0;
        bin_high[i]  = 0;
      end
      floor_lim   = FLOOR_RESET;
      ceiling_lim = CEILING_RESET;
      awaited_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FLOOR) begin
          floor_lim = $signed(cfg_data);
        end else if (cfg_index == REG_CEILING) begin
          ceiling_lim = $signed(cfg_data);
        end
      end
      // Results are taken before the new command, so a word can never be
      // matched against the command accepted on the same edge.
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          $error("result word %h arrived with nothing outstanding", out_data);
          mismatch_count++;
        end else begin
          want = awaited_words.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("sample_count", want.sample_count, out_data.sample_count);
          check_field("min_temp", want.min_temp, out_data.min_temp);
          check_field("max_temp", want.max_temp, out_data.max_temp);
          check_field("mean_temp", want.mean_temp, out_data.mean_temp);
        end
      end
      if (in_valid && !in_stall) begin
        awaited_words.push_back(apply_command(in_data));
      end
    end
    pending_words <= awaited_words.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Statistics unit testbench
// Drives add, month query and total query words in random bursts against a
// receiver that stalls on its own pattern, and steps the temperature limits
// through several settings, the extremes and an inverted pair among them.
// ---------------------------------------------------------------------------
module testbench;
  import bmms_pkg::*;

  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam int         PHASES        = 6;
  localparam int         PHASE_WORDS   = 255;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         TAIL_CYCLES   = 40;
  localparam int         CYCLE_LIMIT   = 1000000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  in_word_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_word_t               out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [TEMP_BITS-1:0]    cfg_data;
  int                      failures;
  int                      pending;
  bit                      hold_request = 1'b0;
  int                      burst_left   = 0;

  binned_min_max_mean_stats_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bmms_stats_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_word_t build_word(logic [1:0] c, int m, int t);
    in_word_t w;
    w.cmd         = c;
    w.month       = m[3:0];
    w.temperature = t[TEMP_BITS-1:0];
    return w;
  endfunction

  // Mostly adds within the limits to valid months, with queries mixed in and
  // a share of bad months, rejected samples and the spare command code.
  function automatic in_word_t random_word(int lo, int hi);
    int         pick;
    int         m;
    int         t;
    logic [1:0] c;
    pick = $urandom_range(0, 99);
    m    = $urandom_range(1, NUM_BINS);
    t    = $urandom_range(0, 255);
    if (pick < 55) begin
      c = CMD_ADD;
      if (lo <= hi && $urandom_range(0, 9) != 0) t = lo + $urandom_range(0, hi - lo);
    end else if (pick < 63) begin
      c = CMD_ADD;
      m = $urandom_range(0, 15);
    end else if (pick < 80) begin
      c = CMD_QUERY;
    end else if (pick < 86) begin
      c = CMD_QUERY;
      m = $urandom_range(0, 15);
    end else if (pick < 95) begin
      c = CMD_TOTAL;
    end else begin
      c = CMD_SPARE;
      m = $urandom_range(0, 15);
    end
    return build_word(c, m, t);
  endfunction

  // Offers one word and returns at the edge that accepts it. Words go out in
  // bursts with random gaps between them.
  task automatic offer_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer(logic [1:0] c, int m, int t);
    offer_word(build_word(c, m, t));
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(int lo, int hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLOOR;
    cfg_data  <= lo[TEMP_BITS-1:0];
    @(posedge clk);
    cfg_index <= REG_CEILING;
    cfg_data  <= hi[TEMP_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int  mode;
    int  span;
    bit  hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        // Long hold-off: the unit fills up and has to stall its input.
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 120);
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase_floor [PHASES];
    int phase_ceiling [PHASES];
    int lo;
    int hi;
    phase_floor   = '{-128, -99, -40, 12, 0, 0};
    phase_ceiling = '{127, 99, 60, -12, 0, 0};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FLOOR;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_limits(-99, 99);

    // Empty bins, bad months, limits taken inclusively and just past them.
    offer(CMD_TOTAL, 0, 0);
    offer(CMD_QUERY, 5, 0);
    offer(CMD_ADD, 0, 10);
    offer(CMD_ADD, 13, 10);
    offer(CMD_ADD, 15, -1);
    offer(CMD_QUERY, 0, 0);
    offer(CMD_QUERY, 14, 0);
    offer(CMD_ADD, 1, 99);
    offer(CMD_ADD, 1, -99);
    offer(CMD_ADD, 1, 100);
    offer(CMD_ADD, 1, -100);
    offer(CMD_ADD, 12, 127);
    offer(CMD_ADD, 12, -128);
    // The first sample sets min and max; a negative mean truncates toward zero.
    offer(CMD_ADD, 12, 5);
    offer(CMD_ADD, 12, -7);
    offer(CMD_ADD, 12, 0);
    offer(CMD_QUERY, 12, 0);
    offer(CMD_TOTAL, 9, 0);
    offer(CMD_SPARE, 0, -1);
    drain_block();
    set_limits(-128, 127);
    offer(CMD_ADD, 6, 127);
    offer(CMD_ADD, 6, -128);
    offer(CMD_QUERY, 6, 0);
    drain_block();
    // Floor above ceiling: every sample is turned away.
    set_limits(10, -10);
    offer(CMD_ADD, 3, 0);
    offer(CMD_ADD, 3, 10);
    offer(CMD_TOTAL, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      lo = phase_floor[p];
      hi = phase_ceiling[p];
      if (p == PHASES - 1) begin
        lo = $signed(8'($urandom_range(0, 255)));
        hi = $signed(8'($urandom_range(0, 255)));
      end
      drain_block();
      set_limits(lo, hi);
      // The long hold-off starts while the first phase is still sending.
      if (p == 0) begin
        hold_request <= 1'b1;
      end
      repeat (PHASE_WORDS) offer_word(random_word(lo, hi));
    end

    drain_block();
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bmms_pkg.sv
rtl/bmms_ram.sv
rtl/binned_min_max_mean_stats_unit.sv
bench/bmms_stats_checker.sv
bench/testbench.sv
